### src/ate_pkg.sv
// Shared types and constants for the array table engine.
// Holds the operation and status codes, the cell command struct and sizes.
// No dependencies.
package ate_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] OP_APPEND  = 3'd0;
    localparam logic [2:0] OP_MINIMUM = 3'd1;
    localparam logic [2:0] OP_REPLACE = 3'd2;
    localparam logic [2:0] OP_INSERT  = 3'd3;
    localparam logic [2:0] OP_DELETE  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_REPLACE,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic signed [DATA_W-1:0]   value;
        logic signed [DATA_W-1:0]   replacement;
        logic [CNT_W-1:0]           count;
        logic [CNT_W-1:0]           position;
    } t_cell_cmd;

endpackage

### src/array_table_engine.sv
// Array table engine: append, minimum and refused requests give one result;
// replace and insert dump the entries, one entry per cycle unless stalled;
// delete drops every match, then dumps. One request at a time: the chain
// rotates once per dumped entry or scanned entry, and compaction removes one
// match per cycle through the cell row. Synchronous active-low reset clears
// the count and control; entries stay undefined until written.
module array_table_engine import ate_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_operation,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_replacement,
    input  logic [CNT_W-1:0]         i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_entry_index,
    output logic signed [DATA_W-1:0] o_entry_value,
    output logic signed [DATA_W-1:0] o_minimum,
    output logic [CNT_W-1:0]         o_count,
    output logic [1:0]               o_status,
    output logic                     o_last
);

    typedef enum logic [2:0] {S_IDLE, S_ONE, S_MIN, S_DEL, S_DUMP} t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [IDX_W-1:0]         r_k, n_k;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic signed [DATA_W-1:0] r_min, n_min;
    logic [IDX_W-1:0]         r_p_index, n_p_index;
    logic signed [DATA_W-1:0] r_p_value, n_p_value;
    logic signed [DATA_W-1:0] r_p_min, n_p_min;
    logic [1:0]               r_p_status, n_p_status;
    logic                     r_o_valid, n_o_valid;
    logic [IDX_W-1:0]         r_o_index, n_o_index;
    logic signed [DATA_W-1:0] r_o_value, n_o_value;
    logic signed [DATA_W-1:0] r_o_min, n_o_min;
    logic [CNT_W-1:0]         r_o_count, n_o_count;
    logic [1:0]               r_o_status, n_o_status;
    logic                     r_o_last, n_o_last;

    t_cell_cmd                cmd;
    logic signed [DATA_W-1:0] head;
    logic                     hit;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     out_free;
    logic                     last_k;
    logic signed [DATA_W-1:0] min_next;

    ate_chain u_chain (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .o_head (head),
        .o_hit  (hit)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign full       = r_count >= CNT_W'(CAPACITY);
    assign empty      = (r_count == '0);
    assign out_free   = !r_o_valid || !i_out_stall;
    assign last_k     = (CNT_W'(r_k) == r_count - CNT_W'(1));
    assign min_next   = ((r_k == '0) || (head < r_min)) ? head : r_min;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_val      = r_val;
        n_min      = r_min;
        n_p_index  = r_p_index;
        n_p_value  = r_p_value;
        n_p_min    = r_p_min;
        n_p_status = r_p_status;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_index  = r_o_index;
        n_o_value  = r_o_value;
        n_o_min    = r_o_min;
        n_o_count  = r_o_count;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;

        cmd.op          = CELL_HOLD;
        cmd.value       = r_val;
        cmd.replacement = i_replacement;
        cmd.count       = r_count;
        cmd.position    = i_position;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_p_index  = '0;
                    n_p_value  = '0;
                    n_p_min    = '0;
                    n_p_status = ST_OK;
                    n_k        = '0;
                    case (i_operation)
                        OP_APPEND: begin
                            n_state = S_ONE;
                            if (full) begin
                                n_p_status = ST_FULL;
                            end else begin
                                cmd.op    = CELL_WRITE;
                                cmd.value = i_value;
                                n_count   = r_count + CNT_W'(1);
                                n_p_index = r_count[IDX_W-1:0];
                                n_p_value = i_value;
                            end
                        end
                        OP_MINIMUM: begin
                            if (empty) begin
                                n_p_status = ST_EMPTY;
                                n_state    = S_ONE;
                            end else begin
                                n_state = S_MIN;
                            end
                        end
                        OP_REPLACE: begin
                            if (empty) begin
                                n_p_status = ST_EMPTY;
                                n_state    = S_ONE;
                            end else begin
                                cmd.op    = CELL_REPLACE;
                                cmd.value = i_value;
                                n_state   = S_DUMP;
                            end
                        end
                        OP_INSERT: begin
                            if (full) begin
                                n_p_status = ST_FULL;
                                n_state    = S_ONE;
                            end else if (i_position > r_count) begin
                                n_p_status = ST_BADPOS;
                                n_state    = S_ONE;
                            end else begin
                                cmd.op    = CELL_INSERT;
                                cmd.value = i_value;
                                n_count   = r_count + CNT_W'(1);
                                n_state   = S_DUMP;
                            end
                        end
                        OP_DELETE: begin
                            if (empty) begin
                                n_p_status = ST_EMPTY;
                                n_state    = S_ONE;
                            end else begin
                                n_val   = i_value;
                                n_state = S_DEL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_index  = r_p_index;
                    n_o_value  = r_p_value;
                    n_o_min    = r_p_min;
                    n_o_count  = r_count;
                    n_o_status = r_p_status;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_MIN: begin
                // scan the head while rotating the filled part once round
                cmd.op = CELL_ROTATE;
                n_min  = min_next;
                n_k    = r_k + IDX_W'(1);
                if (last_k) begin
                    n_p_min = min_next;
                    n_state = S_ONE;
                end
            end
            S_DEL: begin
                // drop the lowest match each cycle until none is left
                cmd.op = CELL_DELETE;
                if (hit) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_k     = '0;
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_min    = '0;
                    n_o_count  = r_count;
                    n_o_status = ST_OK;
                    if (empty) begin
                        n_o_index = '0;
                        n_o_value = '0;
                        n_o_last  = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        cmd.op    = CELL_ROTATE;
                        n_o_index = r_k;
                        n_o_value = head;
                        n_o_last  = last_k;
                        n_k       = r_k + IDX_W'(1);
                        if (last_k) n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_k        <= n_k;
        r_val      <= n_val;
        r_min      <= n_min;
        r_p_index  <= n_p_index;
        r_p_value  <= n_p_value;
        r_p_min    <= n_p_min;
        r_p_status <= n_p_status;
        r_o_index  <= n_o_index;
        r_o_value  <= n_o_value;
        r_o_min    <= n_o_min;
        r_o_count  <= n_o_count;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid   = r_o_valid;
    assign o_entry_index = r_o_index;
    assign o_entry_value = r_o_value;
    assign o_minimum     = r_o_min;
    assign o_count       = r_o_count;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_del_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL && hit) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("compaction step did not shrink the count");

    a_mid_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (r_state == S_DUMP))
        else $error("non-final result outside a dump");

    a_min_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIN) |-> (r_count != '0))
        else $error("minimum scan on an empty array");

endmodule

### src/ate_cell.sv
// One storage cell of the entry chain: holds a single word.
// Takes a broadcast command and trades data with its neighbours; uses ate_pkg.
module ate_cell import ate_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    input  logic signed [DATA_W-1:0] i_head,
    input  logic                     i_hole,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_hole
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [CNT_W-1:0]         idx_ext;
    logic                     live;
    logic                     hit;

    assign idx_ext = CNT_W'(i_index);
    assign live    = idx_ext < i_cmd.count;
    assign hit     = live && (r_data == i_cmd.value);
    // a hole at or below this cell pulls the upper part of the chain down
    assign o_hole  = i_hole | hit;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_WRITE: begin
                if (idx_ext == i_cmd.count) n_data = i_cmd.value;
            end
            CELL_REPLACE: begin
                if (hit) n_data = i_cmd.replacement;
            end
            CELL_INSERT: begin
                if (idx_ext == i_cmd.position) begin
                    n_data = i_cmd.value;
                end else if (idx_ext > i_cmd.position) begin
                    n_data = i_left;
                end
            end
            CELL_DELETE: begin
                if (o_hole) n_data = i_right;
            end
            CELL_ROTATE: begin
                // wrap the head round to the top of the filled part
                if (idx_ext == i_cmd.count - CNT_W'(1)) begin
                    n_data = i_head;
                end else begin
                    n_data = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

### src/ate_chain.sv
// Row of CAPACITY entry cells wired to their neighbours.
// Exposes the head cell and the match flag of the compaction step; uses ate_pkg, ate_cell.
module ate_chain import ate_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    output logic signed [DATA_W-1:0] o_head,
    output logic                     o_hit
);

    logic signed [DATA_W-1:0] data  [CAPACITY];
    logic signed [DATA_W-1:0] left  [CAPACITY];
    logic signed [DATA_W-1:0] right [CAPACITY];
    logic [CAPACITY:0]        hole;

    assign hole[0] = 1'b0;
    assign o_head  = data[0];
    assign o_hit   = hole[CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left[g] = '0;
        end else begin : g_mid_l
            assign left[g] = data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right[g] = '0;
        end else begin : g_mid_r
            assign right[g] = data[g+1];
        end

        ate_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_index (IDX_W'(g)),
            .i_left  (left[g]),
            .i_right (right[g]),
            .i_head  (data[0]),
            .i_hole  (hole[g]),
            .o_data  (data[g]),
            .o_hole  (hole[g+1])
        );
    end

endmodule
